>>> rtl/core/backslash_escape_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the backslash escape decoder
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH

// Property must hold on every clock edge.
`define BSED_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define BSED_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bsed_pkg.sv
// ----------------------------------------------------------------------------
// bsed_pkg
// Types and constants shared by the backslash escape decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bsed_pkg;

   localparam int NUM_SLOTS = 4;
   localparam int COUNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int IDX_W     = $clog2(NUM_SLOTS);

   // configuration register indexes
   localparam logic CSR_ESCAPES  = 1'b0;
   localparam logic CSR_SUPPRESS = 1'b1;

   localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_LC_X    = 8'h78;
   localparam logic [7:0] CHAR_LC_A    = 8'h61;
   localparam logic [7:0] CHAR_LC_B    = 8'h62;
   localparam logic [7:0] CHAR_LC_C    = 8'h63;
   localparam logic [7:0] CHAR_LC_E    = 8'h65;
   localparam logic [7:0] CHAR_LC_F    = 8'h66;
   localparam logic [7:0] CHAR_LC_N    = 8'h6E;
   localparam logic [7:0] CHAR_LC_R    = 8'h72;
   localparam logic [7:0] CHAR_LC_T    = 8'h74;
   localparam logic [7:0] CHAR_LC_V    = 8'h76;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CTRL_BEL     = 8'h07;
   localparam logic [7:0] CTRL_BS      = 8'h08;
   localparam logic [7:0] CTRL_ESC     = 8'h1B;
   localparam logic [7:0] CTRL_FF      = 8'h0C;
   localparam logic [7:0] CTRL_CR      = 8'h0D;
   localparam logic [7:0] CTRL_TAB     = 8'h09;
   localparam logic [7:0] CTRL_VT      = 8'h0B;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_BSLASH,
      MODE_OCTAL,
      MODE_HEX1,
      MODE_HEX2,
      MODE_STOPPED
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [8:0]  value;
      logic [1:0]  digits;
   } dec_state_type;

   localparam dec_state_type IDLE_STATE = '{mode: MODE_NORMAL, value: 9'd0, digits: 2'd0};

   typedef struct packed {
      logic escapes;
      logic suppress;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic       done;
   } rsp_entry_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                 count;
      rsp_entry_type [NUM_SLOTS-1:0]      entry;
      dec_state_type                      next;
   } dec_result_type;

endpackage

`default_nettype wire

>>> rtl/core/bsed_decode.sv
// ----------------------------------------------------------------------------
// bsed_decode
// Combinational decode of one request: result bytes and next decoder state.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_decode (
   input  wire bsed_pkg::dec_state_type  state_cur,
   input  wire bsed_pkg::cfg_type        cfg,
   input  wire logic [7:0]               in_byte,
   input  wire logic                     byte_present,
   input  wire logic                     end_of_arg,
   input  wire logic                     end_of_message,
   output bsed_pkg::dec_result_type      result
);

   function automatic bsed_pkg::rsp_entry_type mk(input logic [7:0] b);
      bsed_pkg::rsp_entry_type r;
      r.data  = b;
      r.valid = 1'b1;
      r.last  = 1'b0;
      r.done  = 1'b0;
      return r;
   endfunction

   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, b[3:0]};
      else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
         r = {1'b1, b[3:0] + 4'd9};
      return r;
   endfunction

   bsed_pkg::dec_state_type                       st;
   bsed_pkg::rsp_entry_type [bsed_pkg::NUM_SLOTS-1:0] e;
   logic [bsed_pkg::COUNT_W-1:0]                  n;
   logic                                          eoa;
   logic                                          is_oct;
   logic [4:0]                                    hx;

   always_comb begin
      st     = state_cur;
      e      = '0;
      n      = '0;
      eoa    = end_of_arg | end_of_message;
      is_oct = (in_byte[7:3] == 5'b00110);
      hx     = hex_digit(in_byte);

      if (st.mode == bsed_pkg::MODE_STOPPED) begin
         // swallow everything until the message ends
         if (end_of_message) st = bsed_pkg::IDLE_STATE;
      end else begin
         if (byte_present) begin
            if (cfg.escapes) begin
               unique case (st.mode)
                  bsed_pkg::MODE_BSLASH: begin
                     st = bsed_pkg::IDLE_STATE;
                     case (in_byte)
                        bsed_pkg::CHAR_BSLASH: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_BSLASH); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_A: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CTRL_BEL); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_B: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CTRL_BS); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_E: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CTRL_ESC); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_F: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CTRL_FF); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_N: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_NL); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_R: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CTRL_CR); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_T: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CTRL_TAB); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_V: begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CTRL_VT); n = n + 1'b1;
                        end
                        bsed_pkg::CHAR_LC_C: begin
                           // stop marker, no byte
                           e[n[bsed_pkg::IDX_W-1:0]] = '0; n = n + 1'b1;
                           st.mode = bsed_pkg::MODE_STOPPED;
                        end
                        bsed_pkg::CHAR_ZERO: begin
                           st.mode   = bsed_pkg::MODE_OCTAL;
                           st.digits = 2'd3;
                        end
                        bsed_pkg::CHAR_LC_X: begin
                           st.mode = bsed_pkg::MODE_HEX1;
                        end
                        default: begin
                           if (is_oct) begin
                              st.mode   = bsed_pkg::MODE_OCTAL;
                              st.value  = {6'd0, in_byte[2:0]};
                              st.digits = 2'd2;
                           end else begin
                              e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_BSLASH); n = n + 1'b1;
                              e[n[bsed_pkg::IDX_W-1:0]] = mk(in_byte); n = n + 1'b1;
                           end
                        end
                     endcase
                  end
                  bsed_pkg::MODE_OCTAL: begin
                     if (is_oct && st.digits != 2'd0) begin
                        st.value  = {st.value[5:0], in_byte[2:0]};
                        st.digits = st.digits - 2'd1;
                        if (st.digits == 2'd0) begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(st.value[7:0]); n = n + 1'b1;
                           st = bsed_pkg::IDLE_STATE;
                        end
                     end else begin
                        e[n[bsed_pkg::IDX_W-1:0]] = mk(st.value[7:0]); n = n + 1'b1;
                        st = bsed_pkg::IDLE_STATE;
                        if (in_byte == bsed_pkg::CHAR_BSLASH) st.mode = bsed_pkg::MODE_BSLASH;
                        else begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(in_byte); n = n + 1'b1;
                        end
                     end
                  end
                  bsed_pkg::MODE_HEX1: begin
                     if (hx[4]) begin
                        st.value = {5'd0, hx[3:0]};
                        st.mode  = bsed_pkg::MODE_HEX2;
                     end else begin
                        e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_BSLASH); n = n + 1'b1;
                        e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_LC_X); n = n + 1'b1;
                        st = bsed_pkg::IDLE_STATE;
                        if (in_byte == bsed_pkg::CHAR_BSLASH) st.mode = bsed_pkg::MODE_BSLASH;
                        else begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(in_byte); n = n + 1'b1;
                        end
                     end
                  end
                  bsed_pkg::MODE_HEX2: begin
                     if (hx[4]) begin
                        e[n[bsed_pkg::IDX_W-1:0]] = mk({st.value[3:0], hx[3:0]}); n = n + 1'b1;
                        st = bsed_pkg::IDLE_STATE;
                     end else begin
                        e[n[bsed_pkg::IDX_W-1:0]] = mk(st.value[7:0]); n = n + 1'b1;
                        st = bsed_pkg::IDLE_STATE;
                        if (in_byte == bsed_pkg::CHAR_BSLASH) st.mode = bsed_pkg::MODE_BSLASH;
                        else begin
                           e[n[bsed_pkg::IDX_W-1:0]] = mk(in_byte); n = n + 1'b1;
                        end
                     end
                  end
                  default: begin
                     st = bsed_pkg::IDLE_STATE;
                     if (in_byte == bsed_pkg::CHAR_BSLASH) st.mode = bsed_pkg::MODE_BSLASH;
                     else begin
                        e[n[bsed_pkg::IDX_W-1:0]] = mk(in_byte); n = n + 1'b1;
                     end
                  end
               endcase
            end else begin
               // escapes off: flush whatever is pending, then raw byte
               unique case (st.mode) inside
                  bsed_pkg::MODE_BSLASH: begin
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_BSLASH); n = n + 1'b1;
                  end
                  bsed_pkg::MODE_OCTAL, bsed_pkg::MODE_HEX2: begin
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(st.value[7:0]); n = n + 1'b1;
                  end
                  bsed_pkg::MODE_HEX1: begin
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_BSLASH); n = n + 1'b1;
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_LC_X); n = n + 1'b1;
                  end
                  default: ;
               endcase
               st = bsed_pkg::IDLE_STATE;
               e[n[bsed_pkg::IDX_W-1:0]] = mk(in_byte); n = n + 1'b1;
            end
         end

         if (st.mode == bsed_pkg::MODE_STOPPED) begin
            e[n[bsed_pkg::IDX_W-1:0] - 1'b1].last = 1'b1;
            e[n[bsed_pkg::IDX_W-1:0] - 1'b1].done = 1'b1;
            if (end_of_message) st = bsed_pkg::IDLE_STATE;
         end else begin
            if (eoa) begin
               unique case (st.mode) inside
                  bsed_pkg::MODE_BSLASH: begin
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_BSLASH); n = n + 1'b1;
                  end
                  bsed_pkg::MODE_OCTAL, bsed_pkg::MODE_HEX2: begin
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(st.value[7:0]); n = n + 1'b1;
                  end
                  bsed_pkg::MODE_HEX1: begin
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_BSLASH); n = n + 1'b1;
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_LC_X); n = n + 1'b1;
                  end
                  default: ;
               endcase
               st = bsed_pkg::IDLE_STATE;
               if (end_of_message) begin
                  if (!cfg.suppress) begin
                     e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_NL); n = n + 1'b1;
                  end
                  // nothing else came out: send a bare end marker
                  if (n == '0) begin
                     e[n[bsed_pkg::IDX_W-1:0]] = '0; n = n + 1'b1;
                  end
                  e[n[bsed_pkg::IDX_W-1:0] - 1'b1].done = 1'b1;
               end else begin
                  e[n[bsed_pkg::IDX_W-1:0]] = mk(bsed_pkg::CHAR_SPACE); n = n + 1'b1;
               end
            end
            if (n != '0) e[n[bsed_pkg::IDX_W-1:0] - 1'b1].last = 1'b1;
         end
      end

      result.count = n;
      result.entry = e;
      result.next  = st;
   end

endmodule

`default_nettype wire

>>> rtl/core/backslash_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder_core
// Echo-style backslash escape decoder with a small result buffer.
// ----------------------------------------------------------------------------
// Requests carry one argument byte (or none, for an empty argument) with
// end-of-argument and end-of-message flags. Each request is decoded in the
// cycle it is accepted; its 0 to 4 result bytes land in a four-slot buffer
// and leave on the rsp channel one per cycle while rsp_tready is high, the
// first in the cycle after the request is accepted. While the receiver is
// ready, a request that yields at most one result sustains one request per
// clock; one that yields more holds req_tready low while the buffer drains.
// The buffer drain (one result per cycle while ready) sets the throughput.
// A new request is taken while the last buffered result is being handed
// over, so a stalled receiver stalls the request side as soon as the buffer
// holds any result.
// Reset empties the buffer, returns the decoder to normal mode and clears
// both configuration registers. csr writes are taken at any time but must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module backslash_escape_decoder_core (
   input  wire  logic       clock,
   input  wire  logic       reset,
   input  wire  logic       req_tvalid,
   output logic             req_tready,
   input  wire  logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire  logic [1:0] req_tuser,   // [0] byte_present, [1] end_of_arg
   input  wire  logic       req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  wire  logic       rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [1:0]       rsp_tuser,   // [0] byte_valid, [1] last_of_item
   output logic             rsp_tlast,   // message_done
   input  wire  logic       csr_we,
   input  wire  logic       csr_addr,
   input  wire  logic       csr_wdata
);

   bsed_pkg::dec_state_type                              state_ff, state_in;
   bsed_pkg::cfg_type                                    cfg_ff, cfg_in;
   bsed_pkg::dec_result_type                             dec;
   bsed_pkg::rsp_entry_type [bsed_pkg::NUM_SLOTS-1:0]    slot_ff, slot_in;
   logic [bsed_pkg::COUNT_W-1:0]                         left_ff, left_in;
   logic [bsed_pkg::IDX_W-1:0]                           rd_ff, rd_in;
   bsed_pkg::rsp_entry_type                              head;
   logic                                                 req_fire;
   logic                                                 rsp_fire;

   bsed_decode u_decode (
      .state_cur      (state_ff),
      .cfg            (cfg_ff),
      .in_byte        (req_tdata),
      .byte_present   (req_tuser[0]),
      .end_of_arg     (req_tuser[1]),
      .end_of_message (req_tlast),
      .result         (dec)
   );

   assign head       = slot_ff[rd_ff];
   assign rsp_tvalid = (left_ff != '0);
   assign rsp_tdata  = head.data;
   assign rsp_tuser  = {head.last, head.valid};
   assign rsp_tlast  = head.done;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // free once the buffer is empty or its final result goes out this cycle
   assign req_tready = (left_ff == '0) ||
                       ((left_ff == bsed_pkg::COUNT_W'(1)) && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      left_in  = left_ff;
      rd_in    = rd_ff;
      cfg_in   = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            bsed_pkg::CSR_ESCAPES:  cfg_in.escapes  = csr_wdata;
            bsed_pkg::CSR_SUPPRESS: cfg_in.suppress = csr_wdata;
            default: ;
         endcase
      end
      if (req_fire) begin
         state_in = dec.next;
         slot_in  = dec.entry;
         left_in  = dec.count;
         rd_in    = '0;
      end else if (rsp_fire) begin
         left_in = left_ff - 1'b1;
         rd_in   = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsed_pkg::IDLE_STATE;
         cfg_ff   <= '0;
         left_ff  <= '0;
         rd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
         left_ff  <= left_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

`include "backslash_escape_decoder_core_assert.svh"

   `BSED_ASSERT(a_left_bound, left_ff <= bsed_pkg::COUNT_W'(bsed_pkg::NUM_SLOTS), "buffer overfilled")
   `BSED_ASSERT_IMP(a_rd_in_range, left_ff != '0, ({1'b0, rd_ff} + left_ff) <= bsed_pkg::COUNT_W'(bsed_pkg::NUM_SLOTS), "read pointer past buffered results")
   `BSED_ASSERT_IMP(a_item_end, rsp_tvalid && left_ff == bsed_pkg::COUNT_W'(1), head.last, "final buffered result lacks item end")
   `BSED_ASSERT_IMP(a_done_is_last, rsp_tvalid && head.done, head.last, "message end not on last result of request")
   `BSED_ASSERT_IMP(a_marker_zero, rsp_tvalid && !head.valid, head.done && head.data == 8'd0, "marker result malformed")

endmodule

`default_nettype wire
